// ===== rtl/varint_directory_record_parser_assert.svh =====
// Assertion macros used by the checker file of the directory record parser.
`ifndef VARINT_DIRECTORY_RECORD_PARSER_ASSERT_SVH
`define VARINT_DIRECTORY_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define VDRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser port check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define VDRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser port check failed across cycles");

`endif

// ===== rtl/vdrp_pkg.sv =====
// Package with the types, codes and constants of the directory record parser.
package vdrp_pkg;

    localparam int MAX_NAME_DEFAULT = 64;
    localparam int NAME_LEN_W       = 6;
    localparam int RESULT_DEPTH     = 4;

    localparam logic [31:0] START_OFFSET = 32'd8;
    localparam logic [31:0] SIZE_SAT     = 32'hFFFF_FFFF;

    // Parse phases.
    localparam logic [2:0] PH_TAG    = 3'd0;
    localparam logic [2:0] PH_NLEN   = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_EXTENT = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    // Stop reasons.
    localparam logic [2:0] REASON_END       = 3'd0;
    localparam logic [2:0] REASON_TERM      = 3'd1;
    localparam logic [2:0] REASON_BAD_TAG   = 3'd2;
    localparam logic [2:0] REASON_OVERFLOW  = 3'd3;
    localparam logic [2:0] REASON_NAME_LONG = 3'd4;
    localparam logic [2:0] REASON_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            name_byte;
        logic [NAME_LEN_W-1:0] name_length;
        logic [31:0]           entry_size;
        logic                  size_unbounded;
        logic [2:0]            stop_reason;
        logic                  is_last;
    } result_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] pos;
        logic [31:0] acc;
        logic [5:0]  shift;
        logic        ovf;
        logic [31:0] name_left;
        logic [31:0] ext_left;
        logic        half;
        logic [31:0] sum;
        logic        sum_unb;
        logic        stopped;
    } parse_state_t;

    localparam parse_state_t PARSE_REWIND = '{
        phase:     PH_TAG,
        pos:       START_OFFSET,
        acc:       32'd0,
        shift:     6'd0,
        ovf:       1'b0,
        name_left: 32'd0,
        ext_left:  32'd0,
        half:      1'b0,
        sum:       32'd0,
        sum_unb:   1'b0,
        stopped:   1'b0
    };

endpackage

// ===== rtl/vdrp_step.sv =====
// Combinational next-state and result logic for one directory byte.
module vdrp_step
    import vdrp_pkg::*;
#(
    parameter int MAX_NAME = MAX_NAME_DEFAULT,
    parameter int CW       = $clog2(MAX_NAME)
)
(
    input  logic [31:0]   image_size,
    input  parse_state_t  state_in,
    input  logic [CW-1:0] emitted_in,
    input  logic [7:0]    byte_value,
    output parse_state_t  state_out,
    output logic [CW-1:0] emitted_out,
    output result_t       res0,
    output result_t       res1,
    output logic [1:0]    res_count
);

    localparam int EW = (CW > NAME_LEN_W) ? CW : NAME_LEN_W;

    function automatic result_t make_stop(input logic [2:0] why);
        result_t r;
        r             = '0;
        r.kind        = KIND_STOP;
        r.stop_reason = why;
        return r;
    endfunction

    parse_state_t  ns;
    logic [CW-1:0] ne;
    logic [31:0]   np;
    logic [6:0]    chunk;
    logic [38:0]   shifted;
    logic [31:0]   acc;
    logic          ovf;
    logic [32:0]   sum_wide;
    logic [EW-1:0] len_ext;
    logic          prim_v;
    result_t       prim;
    logic          end_v;
    result_t       end_stop;

    always_comb
    begin
        ns       = state_in;
        ne       = emitted_in;
        np       = state_in.pos + 32'd1;
        chunk    = byte_value[6:0];
        shifted  = 39'(chunk) << state_in.shift[4:0];
        acc      = state_in.acc;
        ovf      = state_in.ovf;
        sum_wide = '0;
        len_ext  = '0;
        prim_v   = 1'b0;
        prim     = '0;
        end_v    = 1'b0;
        end_stop = '0;
        res0     = '0;
        res1     = '0;
        res_count = 2'd0;

        if (state_in.stopped)
        begin
            // Bytes after a stop are dropped.
        end
        else if (state_in.pos >= image_size)
        begin
            prim_v     = 1'b1;
            prim       = make_stop(REASON_END);
            ns.stopped = 1'b1;
        end
        else
        begin
            ns.pos = np;
            if (state_in.phase == PH_NAME)
            begin
                if (emitted_in < CW'(MAX_NAME - 1))
                begin
                    prim_v         = 1'b1;
                    prim.kind      = KIND_NAME;
                    prim.name_byte = byte_value;
                    ne             = emitted_in + 1'b1;
                end
                ns.name_left = state_in.name_left - 32'd1;
                if (ns.name_left == 32'd0)
                begin
                    ns.phase = PH_COUNT;
                end
            end
            else
            begin
                if (!ovf)
                begin
                    if (state_in.shift[5])
                    begin
                        if (chunk != 7'd0)
                        begin
                            ovf = 1'b1;
                        end
                    end
                    else if (|shifted[38:32])
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        acc = acc | shifted[31:0];
                    end
                end

                if (byte_value[7])
                begin
                    if (!state_in.shift[5])
                    begin
                        ns.shift = state_in.shift + 6'd7;
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                    ns.acc = acc;
                    ns.ovf = ovf;
                end
                else
                begin
                    ns.acc   = '0;
                    ns.shift = '0;
                    ns.ovf   = 1'b0;
                    unique case (state_in.phase)
                        PH_TAG:
                        begin
                            if (ovf)
                            begin
                                prim_v = 1'b1;
                                prim   = make_stop(REASON_OVERFLOW);
                            end
                            else if (acc == 32'd0)
                            begin
                                prim_v = 1'b1;
                                prim   = make_stop(REASON_TERM);
                            end
                            else if (acc != 32'd1)
                            begin
                                prim_v = 1'b1;
                                prim   = make_stop(REASON_BAD_TAG);
                            end
                            else
                            begin
                                ns.phase = PH_NLEN;
                            end
                            ns.stopped = prim_v;
                        end
                        PH_NLEN:
                        begin
                            if (ovf)
                            begin
                                prim_v     = 1'b1;
                                prim       = make_stop(REASON_OVERFLOW);
                                ns.stopped = 1'b1;
                            end
                            else if (acc > image_size - np)
                            begin
                                prim_v     = 1'b1;
                                prim       = make_stop(REASON_NAME_LONG);
                                ns.stopped = 1'b1;
                            end
                            else
                            begin
                                ne           = '0;
                                ns.name_left = acc;
                                ns.phase     = (acc == 32'd0) ? PH_COUNT : PH_NAME;
                            end
                        end
                        PH_COUNT:
                        begin
                            if (ovf)
                            begin
                                prim_v     = 1'b1;
                                prim       = make_stop(REASON_OVERFLOW);
                                ns.stopped = 1'b1;
                            end
                            else
                            begin
                                ns.ext_left = acc;
                                ns.sum      = '0;
                                ns.sum_unb  = 1'b0;
                                ns.half     = 1'b0;
                                if (acc == 32'd0)
                                begin
                                    len_ext          = EW'(ne);
                                    prim_v           = 1'b1;
                                    prim.kind        = KIND_RECORD;
                                    prim.name_length = len_ext[NAME_LEN_W-1:0];
                                    ns.phase         = PH_TAG;
                                end
                                else
                                begin
                                    ns.phase = PH_EXTENT;
                                end
                            end
                        end
                        PH_EXTENT:
                        begin
                            // Overflow of the offset varint carries no meaning.
                            if (!state_in.half)
                            begin
                                ns.half = 1'b1;
                            end
                            else
                            begin
                                ns.half  = 1'b0;
                                sum_wide = {1'b0, state_in.sum} + {1'b0, acc};
                                if (ovf || sum_wide[32])
                                begin
                                    ns.sum_unb = 1'b1;
                                end
                                else
                                begin
                                    ns.sum = sum_wide[31:0];
                                end
                                ns.ext_left = state_in.ext_left - 32'd1;
                                if (ns.ext_left == 32'd0)
                                begin
                                    len_ext             = EW'(ne);
                                    prim_v              = 1'b1;
                                    prim.kind           = KIND_RECORD;
                                    prim.name_length    = len_ext[NAME_LEN_W-1:0];
                                    prim.entry_size     = ns.sum_unb ? SIZE_SAT : ns.sum;
                                    prim.size_unbounded = ns.sum_unb;
                                    ns.phase            = PH_TAG;
                                end
                            end
                        end
                        default:
                        begin
                            ns.phase = PH_TAG;
                        end
                    endcase
                end
            end

            if (!ns.stopped && (np >= image_size))
            begin
                end_v      = 1'b1;
                end_stop   = make_stop(((ns.phase == PH_TAG) && (ns.shift == 6'd0)) ?
                                       REASON_END : REASON_TRUNCATED);
                ns.stopped = 1'b1;
            end
        end

        if (prim_v && end_v)
        begin
            res0             = prim;
            res1             = end_stop;
            res1.is_last     = 1'b1;
            res_count        = 2'd2;
        end
        else if (prim_v)
        begin
            res0         = prim;
            res0.is_last = 1'b1;
            res_count    = 2'd1;
        end
        else if (end_v)
        begin
            res0         = end_stop;
            res0.is_last = 1'b1;
            res_count    = 2'd1;
        end

        state_out   = ns;
        emitted_out = ne;
    end

endmodule

// ===== rtl/vdrp_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
module vdrp_result_fifo
    import vdrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       head_valid,
    output result_t    head,
    output logic       room_for_two
);

    localparam int PW   = $clog2(RESULT_DEPTH);
    localparam int CNTW = $clog2(RESULT_DEPTH + 1);

    result_t         entries_reg [RESULT_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CNTW'(push_count) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entries_reg[wr_ptr_reg + PW'(1)] <= push1;
        end
    end

    assign head_valid   = (count_reg != '0);
    assign head         = entries_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNTW'(RESULT_DEPTH - 2));

endmodule

// ===== rtl/varint_directory_record_parser.sv =====
// Top level of the streaming LEB128 directory record parser.
// An accepted byte's results go into the queue and reach the ports behind older ones.
// Throughput: one byte per cycle; each byte yields up to two results into a four-entry
// queue, and in_stall rises while fewer than two queue slots are free.
// Reset (rst_n, asynchronous, active low) sets image_size to 8, rewinds the parser to
// offset 8 and empties the result queue; no clearing pass is needed.
module varint_directory_record_parser
    import vdrp_pkg::*;
#(
    parameter int MAX_NAME = MAX_NAME_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            byte_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic [7:0]            name_byte,
    output logic [NAME_LEN_W-1:0] name_length,
    output logic [31:0]           entry_size,
    output logic                  size_unbounded,
    output logic [2:0]            stop_reason,
    output logic                  is_last
);

    // Width of the count of name bytes handed out for the current record.
    localparam int CW = $clog2(MAX_NAME);

    logic [31:0]   image_size_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic [CW-1:0] emitted_reg;
    logic [CW-1:0] emitted_next;

    result_t       res0;
    result_t       res1;
    logic [1:0]    res_count;
    logic          in_accept;
    logic          room_for_two;
    result_t       head;

    // A request on the input side is taken whenever the queue can absorb the
    // worst case of two results for that byte.
    assign in_stall  = !room_for_two;
    assign in_accept = in_valid && !in_stall;

    // The whole per-byte decision: varint gathering, phase change and the
    // end-of-image check, computed from the registered parser state.
    vdrp_step #(
        .MAX_NAME (MAX_NAME),
        .CW       (CW)
    ) u_step (
        .image_size  (image_size_reg),
        .state_in    (state_reg),
        .emitted_in  (emitted_reg),
        .byte_value  (byte_value),
        .state_out   (state_next),
        .emitted_out (emitted_next),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    // Parser state advances only on an accepted byte; a write of image_size rewinds it.
    // The user must write image_size only while the block is idle; it is not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= START_OFFSET;
            state_reg      <= PARSE_REWIND;
            emitted_reg    <= '0;
        end
        else if (cfg_we)
        begin
            image_size_reg <= cfg_wdata;
            state_reg      <= PARSE_REWIND;
            emitted_reg    <= '0;
        end
        else if (in_accept)
        begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
        end
    end

    // Results sit in the queue so the input keeps flowing while a result
    // request waits on the output side.
    vdrp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (in_accept ? res_count : 2'd0),
        .push0        (res0),
        .push1        (res1),
        .pop          (out_valid && !out_stall),
        .head_valid   (out_valid),
        .head         (head),
        .room_for_two (room_for_two)
    );

    assign result_kind    = head.kind;
    assign name_byte      = head.name_byte;
    assign name_length    = head.name_length;
    assign entry_size     = head.entry_size;
    assign size_unbounded = head.size_unbounded;
    assign stop_reason    = head.stop_reason;
    assign is_last        = head.is_last;

endmodule

// ===== rtl/vdrp_checker.sv =====
// Port checker for the directory record parser and its bind to the top level.
`include "varint_directory_record_parser_assert.svh"

module vdrp_checker
    import vdrp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            result_kind,
    input logic [NAME_LEN_W-1:0] name_length,
    input logic [31:0]           entry_size,
    input logic                  size_unbounded,
    input logic [2:0]            stop_reason,
    input logic                  is_last
);

    // A stalled result request keeps its contents.
    `VDRP_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(entry_size) && $stable(stop_reason) && $stable(name_length))

    // Only the three defined kinds appear.
    `VDRP_ASSERT_SAME(a_kind_known, out_valid, result_kind == KIND_NAME || result_kind == KIND_RECORD || result_kind == KIND_STOP)

    // A stop is always the last result of its byte and carries a defined reason.
    `VDRP_ASSERT_SAME(a_stop_last, out_valid && result_kind == KIND_STOP, is_last && stop_reason <= REASON_TRUNCATED)

    // An unbounded record reports the saturated size.
    `VDRP_ASSERT_SAME(a_unbounded_sat, out_valid && result_kind == KIND_RECORD && size_unbounded, entry_size == SIZE_SAT)

    // Results other than a stop leave the reason at zero.
    `VDRP_ASSERT_SAME(a_reason_clear, out_valid && result_kind != KIND_STOP, stop_reason == REASON_END)

endmodule

bind varint_directory_record_parser vdrp_checker u_vdrp_checker (.*);

// ===== tb/vdrp_result_checker.sv =====
// Result checker for the directory record parser: predicts every result and compares it.
module vdrp_result_checker
    import vdrp_pkg::*;
#(
    parameter int NAME_MAX = MAX_NAME_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            byte_value,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            result_kind,
    input  logic [7:0]            name_byte,
    input  logic [NAME_LEN_W-1:0] name_length,
    input  logic [31:0]           entry_size,
    input  logic                  size_unbounded,
    input  logic [2:0]            stop_reason,
    input  logic                  is_last,
    output int                    mismatches,
    output int                    pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] image_limit;
    logic [2:0]  phase_now;
    logic [31:0] offset_now;
    logic [31:0] acc_value;
    logic [5:0]  acc_shift;
    logic        acc_overflow;
    logic [31:0] name_remaining;
    int          name_kept;
    logic [31:0] extents_remaining;
    logic        at_size_half;
    logic [31:0] size_total;
    logic        size_overflowed;
    logic        halted;

    result_t results_due [$];
    result_t byte_results [$];

    initial mismatches = 0;
    initial pending = 0;

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] nb,
                                            logic [NAME_LEN_W-1:0] nl, logic [31:0] sz,
                                            logic unb, logic [2:0] why);
        result_t r;
        r = '0;
        r.kind           = kind;
        r.name_byte      = nb;
        r.name_length    = nl;
        r.entry_size     = sz;
        r.size_unbounded = unb;
        r.stop_reason    = why;
        return r;
    endfunction

    task automatic rewind_parser();
        phase_now         = PH_TAG;
        offset_now        = START_OFFSET;
        acc_value         = '0;
        acc_shift         = '0;
        acc_overflow      = 1'b0;
        name_remaining    = '0;
        name_kept         = 0;
        extents_remaining = '0;
        at_size_half      = 1'b0;
        size_total        = '0;
        size_overflowed   = 1'b0;
        halted            = 1'b0;
    endtask

    task automatic note_stop(input logic [2:0] why);
        byte_results.push_back(make_result(KIND_STOP, '0, '0, '0, 1'b0, why));
        halted = 1'b1;
    endtask

    task automatic note_record();
        byte_results.push_back(make_result(KIND_RECORD, '0, NAME_LEN_W'(name_kept),
                                           size_overflowed ? SIZE_SAT : size_total,
                                           size_overflowed, '0));
        phase_now = PH_TAG;
    endtask

    // Walks the parser over one accepted byte and queues the results it causes.
    task automatic advance_parser(input logic [7:0] b);
        logic [31:0] chunk;
        logic [31:0] value;
        logic        value_ovf;
        result_t     tail;
        byte_results.delete();
        if (halted) begin
            // Nothing more comes out until the next rewind.
        end else if (offset_now >= image_limit) begin
            note_stop(REASON_END);
        end else begin
            offset_now++;
            if (phase_now == PH_NAME) begin
                if (name_kept < NAME_MAX - 1) begin
                    byte_results.push_back(make_result(KIND_NAME, b, '0, '0, 1'b0, '0));
                    name_kept++;
                end
                name_remaining--;
                if (name_remaining == 0)
                    phase_now = PH_COUNT;
            end else begin
                chunk = {25'd0, b[6:0]};
                if (!acc_overflow) begin
                    if (acc_shift >= 32) begin
                        if (chunk != 0)
                            acc_overflow = 1'b1;
                    end else if (chunk > (SIZE_SAT >> acc_shift)) begin
                        acc_overflow = 1'b1;
                    end else begin
                        acc_value = acc_value | (chunk << acc_shift);
                    end
                end
                if (b[7]) begin
                    if (acc_shift < 32)
                        acc_shift = acc_shift + 6'd7;
                    else
                        acc_overflow = 1'b1;
                end else begin
                    value        = acc_value;
                    value_ovf    = acc_overflow;
                    acc_value    = '0;
                    acc_shift    = '0;
                    acc_overflow = 1'b0;
                    case (phase_now)
                        PH_TAG: begin
                            if (value_ovf)
                                note_stop(REASON_OVERFLOW);
                            else if (value == 0)
                                note_stop(REASON_TERM);
                            else if (value != 1)
                                note_stop(REASON_BAD_TAG);
                            else
                                phase_now = PH_NLEN;
                        end
                        PH_NLEN: begin
                            if (value_ovf) begin
                                note_stop(REASON_OVERFLOW);
                            end else if (value > image_limit - offset_now) begin
                                note_stop(REASON_NAME_LONG);
                            end else begin
                                name_kept      = 0;
                                name_remaining = value;
                                phase_now      = (value == 0) ? PH_COUNT : PH_NAME;
                            end
                        end
                        PH_COUNT: begin
                            if (value_ovf) begin
                                note_stop(REASON_OVERFLOW);
                            end else begin
                                extents_remaining = value;
                                size_total        = '0;
                                size_overflowed   = 1'b0;
                                at_size_half      = 1'b0;
                                if (value == 0)
                                    note_record();
                                else
                                    phase_now = PH_EXTENT;
                            end
                        end
                        default: begin
                            // Offsets are skipped, overflow included.
                            if (!at_size_half) begin
                                at_size_half = 1'b1;
                            end else begin
                                at_size_half = 1'b0;
                                if (value_ovf || size_total > SIZE_SAT - value)
                                    size_overflowed = 1'b1;
                                else
                                    size_total = size_total + value;
                                extents_remaining--;
                                if (extents_remaining == 0)
                                    note_record();
                            end
                        end
                    endcase
                end
            end
            if (!halted && offset_now >= image_limit)
                note_stop((phase_now == PH_TAG && acc_shift == 0) ? REASON_END
                                                                  : REASON_TRUNCATED);
        end
        if (byte_results.size() > 0) begin
            tail = byte_results.pop_back();
            tail.is_last = 1'b1;
            byte_results.push_back(tail);
        end
        foreach (byte_results[i])
            results_due.push_back(byte_results[i]);
    endtask

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected kind %0d byte %02h len %0d size %08h unb %0b why %0d last %0b, got kind %0d byte %02h len %0d size %08h unb %0b why %0d last %0b",
                     $time, what,
                     want.kind, want.name_byte, want.name_length, want.entry_size,
                     want.size_unbounded, want.stop_reason, want.is_last,
                     got.kind, got.name_byte, got.name_length, got.entry_size,
                     got.size_unbounded, got.stop_reason, got.is_last);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t got;
        result_t want;
        if (!rst_n) begin
            image_limit = START_OFFSET;
            rewind_parser();
            results_due.delete();
        end else begin
            if (out_valid && !out_stall) begin
                got.kind           = result_kind;
                got.name_byte      = name_byte;
                got.name_length    = name_length;
                got.entry_size     = entry_size;
                got.size_unbounded = size_unbounded;
                got.stop_reason    = stop_reason;
                got.is_last        = is_last;
                if (results_due.size() == 0) begin
                    log_mismatch("result with none expected", '0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.name_byte !== want.name_byte ||
                        got.name_length !== want.name_length ||
                        got.entry_size !== want.entry_size ||
                        got.size_unbounded !== want.size_unbounded ||
                        got.stop_reason !== want.stop_reason ||
                        got.is_last !== want.is_last)
                        log_mismatch("wrong result", want, got);
                end
            end
            if (cfg_we) begin
                image_limit = cfg_wdata;
                rewind_parser();
            end
            if (in_valid && !in_stall)
                advance_parser(byte_value);
        end
        pending = results_due.size();
    end

endmodule

// ===== tb/varint_directory_record_parser_tb.sv =====
// Testbench top for the directory record parser: stimulus, flow control and verdict.
module varint_directory_record_parser_tb
    import vdrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // About this many live bytes go into the random part of the run.
    localparam int RANDOM_ITEMS = 850;
    // Cycles allowed after the last expected result before a register write or the verdict.
    localparam int DRAIN_CYCLES = 8;
    // Receiver hold-off that fills the result queue and backs up the input.
    localparam int LONG_HOLD = 80;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [31:0]           cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            byte_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            result_kind;
    logic [7:0]            name_byte;
    logic [NAME_LEN_W-1:0] name_length;
    logic [31:0]           entry_size;
    logic                  size_unbounded;
    logic [2:0]            stop_reason;
    logic                  is_last;

    int mismatch_total;
    int results_pending;
    int cycle_count = 0;

    // The image bytes of the current phase, starting at offset eight.
    logic [7:0] image_q [$];

    // When set, every request of the phase is offered back to back, but for a drain pause.
    bit sender_calm = 1'b0;
    // Raised once by the stimulus to ask the receiver for its long hold-off.
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    varint_directory_record_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .name_byte      (name_byte),
        .name_length    (name_length),
        .entry_size     (entry_size),
        .size_unbounded (size_unbounded),
        .stop_reason    (stop_reason),
        .is_last        (is_last)
    );

    vdrp_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .name_byte      (name_byte),
        .name_length    (name_length),
        .entry_size     (entry_size),
        .size_unbounded (size_unbounded),
        .stop_reason    (stop_reason),
        .is_last        (is_last),
        .mismatches     (mismatch_total),
        .pending        (results_pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A hard ceiling on the run in case the block hangs or drops results.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL varint_directory_record_parser");
                $finish;
            end
        end
    end

    // Receiver side. Most stretches are short random stalls, some are long stalls,
    // some are long stretches of full rate. The single long hold-off is requested by
    // the stimulus while it streams a phase that yields many results, so the result
    // queue fills and the block has to stall its input.
    initial
    begin : receiver
        int  len;
        bit  stall_now;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                stall_now = 1'b1;
                len = LONG_HOLD;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        stall_now = 1'b0;
                        len = 40;
                    end
                    1:
                    begin
                        stall_now = 1'b1;
                        len = $urandom_range(15, 30);
                    end
                    default:
                    begin
                        stall_now = ($urandom_range(0, 2) == 0);
                        len = $urandom_range(1, 3);
                    end
                endcase
            end
            out_stall <= stall_now;
            repeat (len) @(posedge clk);
        end
    end

    // Waits until the checker holds no expected result, then lets the block settle.
    // The count is read at the falling edge, away from the checker's update.
    task automatic wait_drained();
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller makes sure the block is idle.
    task automatic write_image_size(input logic [31:0] size);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offers one byte and returns at the edge where it is accepted. A random gap
    // comes first unless the phase runs calm. With drain_first set, the sender stops
    // offering until every result caused so far has come out.
    task automatic send_byte(input logic [7:0] b, input bit drain_first);
        int gap;
        if (drain_first)
            gap = 1;
        else if (sender_calm)
            gap = 0;
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:54]:  gap = 0;
                [55:84]: gap = $urandom_range(1, 3);
                [85:96]: gap = $urandom_range(4, 10);
                default: gap = $urandom_range(20, 40);
            endcase
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain_first)
                wait_drained();
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Streams image_q as one phase, after rewinding the parser when asked.
    task automatic run_image(input bit rewrite, input logic [31:0] size, input int pause_at,
                             input bit ask_hold);
        int i;
        if (rewrite)
        begin
            wait_drained();
            write_image_size(size);
        end
        if (ask_hold)
            hold_req = 1'b1;
        for (i = 0; i < image_q.size(); i++)
            send_byte(image_q[i], i == pause_at);
        in_valid <= 1'b0;
    endtask

    // Appends an unsigned LEB128 varint, with pad redundant zero groups after the
    // minimal form. Six groups at most, which the parser still takes without overflow.
    task automatic put_varint(input logic [31:0] v, input int pad);
        int          groups;
        int          total;
        int          i;
        logic [31:0] rest;
        groups = 1;
        rest = v >> 7;
        while (rest != 0)
        begin
            groups++;
            rest = rest >> 7;
        end
        total = groups + pad;
        if (total > 6)
            total = 6;
        for (i = 0; i < total; i++)
            image_q.push_back({(i < total - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
    endtask

    // Appends a varint that breaks the 32-bit rule in one of its three ways.
    task automatic put_bad_varint();
        case ($urandom_range(0, 2))
            0:
            begin
                // The fifth group carries bits above bit 31.
                repeat (4) image_q.push_back({1'b1, 7'($urandom)});
                image_q.push_back(8'($urandom_range(16, 127)));
            end
            1:
            begin
                // A continuation after the shift has gone past 32.
                repeat (6) image_q.push_back({1'b1, 7'($urandom)});
                image_q.push_back(8'h00);
            end
            default:
            begin
                // A nonzero sixth group.
                repeat (5) image_q.push_back({1'b1, 7'($urandom)});
                image_q.push_back(8'($urandom_range(1, 127)));
            end
        endcase
    endtask

    function automatic int pick_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Extent offsets and sizes: small, medium, the top value, near the top and full range.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 127);
            1:       return $urandom_range(128, 65535);
            2:       return SIZE_SAT;
            3:       return SIZE_SAT - $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    // Builds one random directory in image_q: a few well-formed records with random
    // content, then one way of ending, then a little noise that the parser must ignore.
    // A busy directory has four records with names and ends exactly at the image end,
    // so its name bytes keep producing results. live_len counts the bytes the parser uses.
    task automatic build_directory(input bit busy, output logic [31:0] size_out,
                                   output int live_len);
        int          n_rec;
        int          ending;
        int          nlen;
        int          n_ext;
        int          r;
        int          e;
        int          i;
        int          extra;
        int          cut;
        logic [31:0] tag;
        image_q.delete();
        n_rec = busy ? 4 : $urandom_range(0, 3);
        for (r = 0; r < n_rec; r++)
        begin
            put_varint(32'd1, pick_pad());
            // Now and then a long name; one over 63 bytes is cut short in the report.
            if ($urandom_range(0, 9) < 2)
                nlen = $urandom_range(13, 70);
            else
                nlen = $urandom_range(busy ? 4 : 0, 12);
            put_varint(nlen, pick_pad());
            for (i = 0; i < nlen; i++)
                image_q.push_back(8'($urandom));
            n_ext = $urandom_range(0, 3);
            put_varint(n_ext, pick_pad());
            for (e = 0; e < n_ext; e++)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_bad_varint();
                else
                    put_varint(pick_value(), pick_pad());
                if ($urandom_range(0, 11) == 0)
                    put_bad_varint();
                else
                    put_varint(pick_value(), pick_pad());
            end
        end

        ending = busy ? 0 : $urandom_range(0, 6);
        size_out = SIZE_SAT;
        case (ending)
            1: put_varint(32'd0, pick_pad());
            2:
            begin
                tag = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(2, 300);
                if (tag < 2)
                    tag = 2;
                put_varint(tag, pick_pad());
            end
            3:
            begin
                // Overflow in the tag, the name length or the extent count.
                extra = $urandom_range(0, 2);
                if (extra >= 1)
                    put_varint(32'd1, pick_pad());
                if (extra == 2)
                    put_varint(32'd0, pick_pad());
                put_bad_varint();
            end
            4:
            begin
                put_varint(32'd1, pick_pad());
                if ($urandom_range(0, 3) == 0)
                    put_varint(SIZE_SAT, 0);
                else
                begin
                    extra = $urandom_range(0, 10);
                    put_varint(extra + 1 + $urandom_range(0, 40), 0);
                    size_out = START_OFFSET + image_q.size() + extra;
                end
            end
            5:
            begin
                // The image ends somewhere inside what was built.
                if (image_q.size() == 0)
                begin
                    put_varint(32'd1, pick_pad());
                    put_varint($urandom_range(0, 5), pick_pad());
                end
                cut = $urandom_range(0, image_q.size() - 1);
                while (image_q.size() > cut)
                    void'(image_q.pop_back());
                size_out = START_OFFSET + cut;
            end
            6:
            begin
                repeat ($urandom_range(4, 16)) image_q.push_back(8'($urandom));
                if ($urandom_range(0, 2) != 0)
                    size_out = START_OFFSET + $urandom_range(0, image_q.size() + 4);
            end
            default: ;
        endcase
        if (ending == 0)
            size_out = START_OFFSET + image_q.size();
        else if (ending <= 3 && $urandom_range(0, 2) != 0)
            size_out = START_OFFSET + image_q.size() + $urandom_range(0, 6);
        live_len = image_q.size();
        repeat ($urandom_range(0, 3)) image_q.push_back(8'($urandom));
    endtask

    initial
    begin : stimulus
        logic [31:0] size_pick;
        int          live;
        int          phase_idx;
        int          sent;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Empty image straight after reset: the first byte only brings a stop, and
        // the byte after it is ignored.
        image_q = '{8'h00, 8'hFF};
        run_image(1'b0, START_OFFSET, -1, 1'b0);
        // Terminator tag and unknown tag in an image with no end in sight.
        image_q = '{8'h00};
        run_image(1'b1, SIZE_SAT, -1, 1'b0);
        image_q = '{8'h7F};
        run_image(1'b1, SIZE_SAT, -1, 1'b0);
        // One record filling the image exactly: a one-byte name, an extent whose
        // offset overflows (and is ignored) and whose size is the top value. The
        // record and the end-of-image stop share the last byte.
        image_q = '{8'h01, 8'h01, 8'hFF, 8'h01,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
        run_image(1'b1, START_OFFSET + 14, -1, 1'b0);
        // A name length decided on the last byte of the image: the length check
        // wins over the end of the image.
        image_q = '{8'h01, 8'h05};
        run_image(1'b1, START_OFFSET + 2, -1, 1'b0);
        // The image ends inside the name length varint.
        image_q = '{8'h01, 8'h80};
        run_image(1'b1, START_OFFSET + 2, -1, 1'b0);
        // Tag with bits beyond 32.
        image_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        run_image(1'b1, SIZE_SAT, -1, 1'b0);

        // Random part. The first phase is busy and calm and carries the receiver's
        // long hold-off; the second pauses halfway until all its results are out.
        sent = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_directory(phase_idx == 0, size_pick, live);
            sender_calm = (phase_idx == 0) || ($urandom_range(0, 5) == 0);
            run_image(1'b1, size_pick, (phase_idx == 1) ? image_q.size() / 2 : -1,
                      phase_idx == 0);
            sent += live;
            phase_idx++;
        end

        wait_drained();
        @(negedge clk);
        if (mismatch_total == 0 && results_pending == 0)
            $display("PASS varint_directory_record_parser");
        else
            $display("FAIL varint_directory_record_parser");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vdrp_pkg.sv
rtl/vdrp_step.sv
rtl/vdrp_result_fifo.sv
rtl/varint_directory_record_parser.sv
rtl/vdrp_checker.sv
tb/vdrp_result_checker.sv
tb/varint_directory_record_parser_tb.sv
